// ----- rtl/der_enc_pkg.sv -----
// Shared constants and types for the DER INTEGER encoder.
// No dependencies; compiled first.
`default_nettype none
package der_enc_pkg;

  localparam int MAX_BYTES_DEF   = 256;
  localparam int MAX_BYTES_LIMIT = 256;
  localparam int WORD_BYTES      = 8;

  localparam logic [7:0] TAG_INTEGER = 8'h02;
  localparam logic [7:0] LEN_LONG    = 8'h80;
  localparam logic [7:0] PAD_BYTE    = 8'h00;
  localparam logic [7:0] TOP_BIT     = 8'h80;

  // Source of the encoded byte pushed in a cycle.
  typedef enum logic [2:0] {
    SEL_TAG,
    SEL_LEN_HDR,
    SEL_LEN_HI,
    SEL_LEN_LO,
    SEL_PAD,
    SEL_VALUE
  } byte_sel_t;

  typedef struct packed {
    logic      store;
    logic      fetch;
    logic      push;
    byte_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic push_ok;
    logic pad;
    logic long_form;
    logic len_two;
    logic final_byte;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/der_enc_ifs.sv -----
// Valid/ready channel interfaces for the encoder's input bytes and output words.
// No dependencies.
`default_nettype none
interface der_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface der_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last_word;
  logic        overflow;

  modport source(output valid, output out_bytes, output byte_count, output last_word,
                 output overflow, input ready);
  modport sink(input valid, input out_bytes, input byte_count, input last_word,
               input overflow, output ready);
endinterface
`default_nettype wire

// ----- rtl/der_enc_ctrl.sv -----
// Controller of the DER INTEGER encoder: collect phase, then one encoded
// byte per step. Depends on der_enc_pkg.
`default_nettype none
module der_enc_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic                   in_last,
  output logic                        in_ready,
  output der_enc_pkg::dp_cmd_t        cmd,
  input  wire der_enc_pkg::dp_status_t status
);
  import der_enc_pkg::*;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_FETCH,
    ST_TAG,
    ST_LEN_HDR,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_PAD,
    ST_VALUE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      case (state)
        ST_COLLECT: if (in_valid && in_last) state <= ST_FETCH;
        ST_FETCH:   state <= ST_TAG;
        ST_TAG:     if (status.push_ok) state <= ST_LEN_HDR;
        ST_LEN_HDR: begin
          if (status.push_ok) begin
            if (status.long_form) state <= status.len_two ? ST_LEN_HI : ST_LEN_LO;
            else                  state <= status.pad ? ST_PAD : ST_VALUE;
          end
        end
        ST_LEN_HI:  if (status.push_ok) state <= ST_LEN_LO;
        ST_LEN_LO:  if (status.push_ok) state <= status.pad ? ST_PAD : ST_VALUE;
        ST_PAD:     if (status.push_ok) state <= ST_VALUE;
        ST_VALUE:   if (status.push_ok && status.final_byte) state <= ST_COLLECT;
        default:    state <= ST_COLLECT;
      endcase
    end
  end

  always_comb begin
    in_ready  = (state == ST_COLLECT);
    cmd.store = in_valid && (state == ST_COLLECT);
    cmd.fetch = (state == ST_FETCH);
    cmd.push  = 1'b0;
    cmd.sel   = SEL_TAG;
    case (state)
      ST_TAG:     begin cmd.push = 1'b1; cmd.sel = SEL_TAG;     end
      ST_LEN_HDR: begin cmd.push = 1'b1; cmd.sel = SEL_LEN_HDR; end
      ST_LEN_HI:  begin cmd.push = 1'b1; cmd.sel = SEL_LEN_HI;  end
      ST_LEN_LO:  begin cmd.push = 1'b1; cmd.sel = SEL_LEN_LO;  end
      ST_PAD:     begin cmd.push = 1'b1; cmd.sel = SEL_PAD;     end
      ST_VALUE:   begin cmd.push = 1'b1; cmd.sel = SEL_VALUE;   end
      default:    begin cmd.push = 1'b0; cmd.sel = SEL_TAG;     end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/der_enc_dp.sv -----
// Datapath of the DER INTEGER encoder: value store, counters, header bytes,
// word packer and output register. Depends on der_enc_pkg.
`default_nettype none
module der_enc_dp #(
  parameter int MAX_BYTES = der_enc_pkg::MAX_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire der_enc_pkg::dp_cmd_t cmd,
  output der_enc_pkg::dp_status_t   status,
  input  wire logic [7:0]           in_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [63:0]               out_bytes,
  output logic [3:0]                byte_count,
  output logic                      last_word,
  output logic                      overflow
);
  import der_enc_pkg::*;

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int LW = $clog2(MAX_BYTES + 2);

  logic [7:0]    mem [MAX_BYTES];
  logic [CW-1:0] count;
  logic [CW-1:0] lzc;
  logic          all_zero;
  logic          ovf_seen;
  logic [7:0]    rd_data;
  logic [AW-1:0] vptr;
  logic [CW-1:0] vrem;
  logic [63:0]   acc;
  logic [2:0]    acc_cnt;

  logic [CW-1:0] kept_m1;
  logic [CW-1:0] skip;
  logic [CW-1:0] vlen;
  logic [LW-1:0] clen;
  logic [15:0]   clen16;
  logic          pad;
  logic          push_ok;
  logic          do_push;
  logic          final_byte;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    push_byte;
  logic [5:0]    shamt;
  logic [63:0]   merged;
  logic          store_ok;

  // Encoding geometry; count and lzc hold still through the emit phase.
  always_comb begin
    kept_m1    = count - CW'(1);
    skip       = (lzc > kept_m1) ? kept_m1 : lzc;
    vlen       = count - skip;
    pad        = rd_data[7];
    clen       = LW'(vlen) + LW'(pad);
    clen16     = 16'(clen);
    push_ok    = !out_valid || out_ready;
    do_push    = cmd.push && push_ok;
    final_byte = (cmd.sel == SEL_VALUE) && (vrem == CW'(1));
    store_ok   = count < CW'(MAX_BYTES);

    status.push_ok    = push_ok;
    status.pad        = pad;
    status.long_form  = clen16 >= 16'h0080;
    status.len_two    = clen16 >= 16'h0100;
    status.final_byte = final_byte;

    rd_en   = cmd.fetch || (do_push && (cmd.sel == SEL_VALUE) && !final_byte);
    rd_addr = cmd.fetch ? skip[AW-1:0] : vptr + AW'(1);

    case (cmd.sel)
      SEL_TAG:     push_byte = TAG_INTEGER;
      SEL_LEN_HDR: push_byte = status.long_form ?
                               (LEN_LONG | (status.len_two ? 8'd2 : 8'd1)) : clen16[7:0];
      SEL_LEN_HI:  push_byte = clen16[15:8];
      SEL_LEN_LO:  push_byte = clen16[7:0];
      SEL_PAD:     push_byte = PAD_BYTE;
      SEL_VALUE:   push_byte = rd_data;
      default:     push_byte = PAD_BYTE;
    endcase

    shamt  = {3'(3'd7 - acc_cnt), 3'b000};
    merged = acc | (64'(push_byte) << shamt);
  end

  // Value store: written in the collect phase, read during emit.
  always_ff @(posedge clk) begin
    if (cmd.store && store_ok) mem[count[AW-1:0]] <= in_byte;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      lzc      <= '0;
      all_zero <= 1'b1;
      ovf_seen <= 1'b0;
    end else if (cmd.store) begin
      if (store_ok) begin
        count <= count + CW'(1);
        if (all_zero) begin
          if (in_byte == 8'h00) lzc <= lzc + CW'(1);
          else                  all_zero <= 1'b0;
        end
      end else begin
        ovf_seen <= 1'b1;
      end
    end else if (do_push && final_byte) begin
      count    <= '0;
      lzc      <= '0;
      all_zero <= 1'b1;
      ovf_seen <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      vptr <= skip[AW-1:0];
      vrem <= vlen;
    end else if (do_push && (cmd.sel == SEL_VALUE)) begin
      vptr <= vptr + AW'(1);
      vrem <= vrem - CW'(1);
    end
  end

  // Packer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      acc_cnt   <= '0;
      out_valid <= 1'b0;
    end else if (do_push) begin
      if (final_byte || (acc_cnt == 3'd7)) begin
        out_bytes  <= merged;
        byte_count <= 4'(acc_cnt) + 4'd1;
        last_word  <= final_byte;
        overflow   <= ovf_seen;
        out_valid  <= 1'b1;
        acc        <= '0;
        acc_cnt    <= '0;
      end else begin
        acc     <= merged;
        acc_cnt <= acc_cnt + 3'd1;
        if (out_ready) out_valid <= 1'b0;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/der_integer_encoder_top.sv -----
// DER INTEGER encoder, top level: controller plus datapath.
// Collect: one input byte per cycle in the collect phase, no stall. After the last byte a
// fetch state reads the first value byte; emit then pushes one encoded byte per cycle while
// the output is not stalled (tag, 1-3 length bytes, optional pad, value bytes), packed
// eight to an output word. Sync reset clears control; no clearing pass needed.
`default_nettype none
module der_integer_encoder_top #(
  parameter int MAX_BYTES = der_enc_pkg::MAX_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  der_in_if.sink   din,
  der_out_if.source dout
);
  import der_enc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller walks the encoding one byte at a time.
  der_enc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_last  (din.last_byte),
    .in_ready (din.ready),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath holds the store and drives the output word register.
  der_enc_dp #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_byte    (din.data_byte),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .out_bytes  (dout.out_bytes),
    .byte_count (dout.byte_count),
    .last_word  (dout.last_word),
    .overflow   (dout.overflow)
  );

endmodule
`default_nettype wire

// ----- rtl/der_enc_checker.sv -----
// Port-level checks for the DER INTEGER encoder, bound to the top level.
// Depends on der_integer_encoder_top and its channel interfaces.
`default_nettype none
module der_enc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_bytes,
  input wire logic [3:0]  byte_count,
  input wire logic        last_word
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != 4'd0) && (byte_count <= 4'd8))
    else $error("byte_count out of range");

  a_full_words: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_word) |-> (byte_count == 4'd8))
    else $error("non-final word not full");

  a_emit_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input taken during emit");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_bytes)))
    else $error("stalled word changed");

endmodule

bind der_integer_encoder_top der_enc_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (din.valid),
  .in_ready   (din.ready),
  .in_last    (din.last_byte),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .out_bytes  (dout.out_bytes),
  .byte_count (dout.byte_count),
  .last_word  (dout.last_word)
);
`default_nettype wire
